// ===== rtl/core/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types and constants of the selective-repeat receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

   // sequence space and payload word
   localparam int SEQ_SPACE    = 16;
   localparam int SEQ_BITS     = $clog2(SEQ_SPACE);
   localparam int PAYLOAD_BITS = 64;
   localparam logic [63:0] PAYLOAD_MASK = {64{1'b1}} >> (64 - PAYLOAD_BITS);

   // configuration registers
   localparam int CFG_BITS  = 5;
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEQ_MODULUS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_SIZE = 2'd1;

   localparam logic [CFG_BITS-1:0] MODULUS_RESET = 5'd8;
   localparam logic [CFG_BITS-1:0] WINDOW_RESET  = 5'd4;
   localparam logic [CFG_BITS-1:0] MODULUS_MIN   = 5'd2;
   localparam logic [CFG_BITS-1:0] MODULUS_MAX   = CFG_BITS'(SEQ_SPACE);
   localparam logic [CFG_BITS-1:0] WINDOW_MIN    = 5'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DELIVER
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic deliver;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ok;
      logic in_window;
      logic ack_last;
      logic next_filled;
   } status_type;

endpackage

// ===== rtl/core/srr_ctrl.sv =====
// ----------------------------------------------------------------------------
// srr_ctrl
// Sequencer: takes an item, evaluates it, then walks the in-order run.
// ----------------------------------------------------------------------------
module srr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  srr_pkg::status_type status,
   output srr_pkg::cmd_type    cmd
);
   import srr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.ok && status.in_window && !status.ack_last) begin
               state_in = ST_DELIVER;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DELIVER: begin
            cmd.deliver = 1'b1;
            if (!status.next_filled) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/srr_dpath.sv =====
// ----------------------------------------------------------------------------
// srr_dpath
// Window state, slot buffer, configuration registers and result register.
// ----------------------------------------------------------------------------
module srr_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  srr_pkg::cmd_type                     cmd,
   output srr_pkg::status_type                  status,
   input  logic                                 req_checksum_ok,
   input  logic [srr_pkg::SEQ_BITS-1:0]         req_seq_num,
   input  logic [63:0]                          req_payload,
   input  logic                                 csr_write,
   input  logic [srr_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [srr_pkg::CFG_BITS-1:0]         csr_data,
   output logic                                 rsp_valid,
   output logic                                 rsp_is_delivery,
   output logic [srr_pkg::SEQ_BITS-1:0]         rsp_ack_num,
   output logic [63:0]                          rsp_data_out,
   output logic                                 rsp_last
);
   import srr_pkg::*;

   logic [CFG_BITS-1:0]  modulus_ff;
   logic [CFG_BITS-1:0]  window_ff;
   logic [SEQ_BITS-1:0]  base_ff;
   logic [SEQ_SPACE-1:0] filled_ff;
   logic [63:0]          slot_mem [SEQ_SPACE];

   logic                 ok_ff;
   logic [SEQ_BITS-1:0]  seq_ff;
   logic [63:0]          payload_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_is_delivery_ff;
   logic [SEQ_BITS-1:0]  rsp_ack_num_ff;
   logic [63:0]          rsp_data_out_ff;
   logic                 rsp_last_ff;

   logic [CFG_BITS-1:0]  eff_mod;
   logic [CFG_BITS-1:0]  eff_win;
   logic [CFG_BITS-1:0]  seq_ext;
   logic [CFG_BITS-1:0]  dist_raw;
   logic [CFG_BITS-1:0]  offset;
   logic                 in_window;
   logic [CFG_BITS-1:0]  base_plus;
   logic [SEQ_BITS-1:0]  base_inc;
   logic                 ack_last;
   logic                 cfg_hit;

   always_comb begin
      // clamp the configuration to its working range
      if (modulus_ff < MODULUS_MIN) begin
         eff_mod = MODULUS_MIN;
      end else if (modulus_ff > MODULUS_MAX) begin
         eff_mod = MODULUS_MAX;
      end else begin
         eff_mod = modulus_ff;
      end
      if (window_ff < WINDOW_MIN) begin
         eff_win = WINDOW_MIN;
      end else if (window_ff > eff_mod) begin
         eff_win = eff_mod;
      end else begin
         eff_win = window_ff;
      end

      // distance from base, mod m; base is below m, seq is checked against m
      seq_ext   = CFG_BITS'(seq_ff);
      dist_raw  = seq_ext + eff_mod - CFG_BITS'(base_ff);
      offset    = (dist_raw >= eff_mod) ? dist_raw - eff_mod : dist_raw;
      in_window = (seq_ext < eff_mod) && (offset < eff_win);

      base_plus = CFG_BITS'(base_ff) + CFG_BITS'(1);
      base_inc  = (base_plus == eff_mod) ? '0 : base_plus[SEQ_BITS-1:0];

      // last result is the ACK unless the base slot is filled once this item is stored
      ack_last = !(filled_ff[base_ff] || (seq_ff == base_ff));

      cfg_hit = csr_write &&
                ((csr_index == CSR_SEQ_MODULUS) || (csr_index == CSR_WINDOW_SIZE));
   end

   assign status.ok          = ok_ff;
   assign status.in_window   = in_window;
   assign status.ack_last    = ack_last;
   assign status.next_filled = filled_ff[base_inc];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
         window_ff  <= WINDOW_RESET;
         base_ff    <= '0;
         filled_ff  <= '0;
      end else if (cfg_hit) begin
         if (csr_index == CSR_SEQ_MODULUS) begin
            modulus_ff <= csr_data;
         end else begin
            window_ff <= csr_data;
         end
         base_ff   <= '0;
         filled_ff <= '0;
      end else if (cmd.eval && ok_ff && in_window) begin
         filled_ff[seq_ff] <= 1'b1;
      end else if (cmd.deliver) begin
         filled_ff[base_ff] <= 1'b0;
         base_ff            <= base_inc;
      end
   end

   // slot buffer
   always_ff @(posedge clock) begin
      if (cmd.eval && ok_ff && in_window) begin
         slot_mem[seq_ff] <= payload_ff;
      end
   end

   // item register
   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff <= 1'b0;
      end else if (cmd.load) begin
         ok_ff <= req_checksum_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         seq_ff     <= req_seq_num;
         payload_ff <= req_payload & PAYLOAD_MASK;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.eval && ok_ff) || cmd.deliver;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         rsp_is_delivery_ff <= 1'b0;
         rsp_ack_num_ff     <= seq_ff;
         rsp_data_out_ff    <= '0;
         rsp_last_ff        <= in_window ? ack_last : 1'b1;
      end else if (cmd.deliver) begin
         rsp_is_delivery_ff <= 1'b1;
         rsp_ack_num_ff     <= '0;
         rsp_data_out_ff    <= slot_mem[base_ff] & PAYLOAD_MASK;
         rsp_last_ff        <= !filled_ff[base_inc];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_delivery = rsp_is_delivery_ff;
   assign rsp_ack_num     = rsp_ack_num_ff;
   assign rsp_data_out    = rsp_data_out_ff;
   assign rsp_last        = rsp_last_ff;

   a_base_in_range: assert property (@(posedge clock) disable iff (reset)
      CFG_BITS'(base_ff) < eff_mod)
      else $error("window base beyond modulus");

   a_deliver_filled: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> filled_ff[base_ff])
      else $error("delivery from an empty slot");

   a_last_then_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result right after a last mark");

   a_delivery_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_is_delivery)
      else $error("run of results broken");

endmodule

// ===== rtl/core/selective_repeat_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit
// Selective-repeat ARQ receiver: acks packets and delivers them in order.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A packet with a bad
// checksum produces nothing and holds busy high for one cycle. Any other
// packet yields an ACK, and an in-window packet is followed by one delivery
// per contiguous buffered slot from the window base, one result per cycle.
// The ACK is registered from the evaluate state and each delivery from a
// deliver state; busy stays high through the evaluate and deliver states,
// so the next item is taken only after the last delivery state. Results
// cannot be held off: each is on the rsp_ ports for one cycle with
// rsp_valid high, and rsp_last marks the final one of an item.
// The sequencer walks the slot buffer one entry per cycle, which sets the
// rate. Configuration writes are taken while busy is low and restart the
// window (base to zero, every slot empty).
module selective_repeat_receiver_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_checksum_ok,
   input  logic [srr_pkg::SEQ_BITS-1:0]     req_seq_num,
   input  logic [63:0]                      req_payload,
   output logic                             rsp_valid,
   output logic                             rsp_is_delivery,
   output logic [srr_pkg::SEQ_BITS-1:0]     rsp_ack_num,
   output logic [63:0]                      rsp_data_out,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [srr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [srr_pkg::CFG_BITS-1:0]     csr_data
);
   import srr_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       busy_int;

   assign busy      = busy_int;
   assign csr_ready = !busy_int;

   srr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy_int),
      .status (status),
      .cmd    (cmd)
   );

   srr_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_checksum_ok (req_checksum_ok),
      .req_seq_num     (req_seq_num),
      .req_payload     (req_payload),
      .csr_write       (csr_valid && !busy_int),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_is_delivery (rsp_is_delivery),
      .rsp_ack_num     (rsp_ack_num),
      .rsp_data_out    (rsp_data_out),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== sim/selective_repeat_receiver_unit_checker.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit_checker
// Watches the packet, result and register channels of the receiver, keeps
// its own copy of the receive window, and compares every result field by
// field with the oldest one still owed. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module selective_repeat_receiver_unit_checker
   import srr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic                    req_checksum_ok,
   input  logic [SEQ_BITS-1:0]     req_seq_num,
   input  logic [63:0]             req_payload,
   input  logic                    rsp_valid,
   input  logic                    rsp_is_delivery,
   input  logic [SEQ_BITS-1:0]     rsp_ack_num,
   input  logic [63:0]             rsp_data_out,
   input  logic                    rsp_last,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_data,
   output logic [SEQ_BITS-1:0]     predicted_base,
   output int                      active_modulus,
   output int                      active_window,
   output int                      awaited_count,
   output int                      error_count
);

   typedef struct packed {
      logic                is_delivery;
      logic [SEQ_BITS-1:0] ack_num;
      logic [63:0]         data_out;
      logic                last;
   } rsp_item_type;

   logic [CFG_BITS-1:0] modulus_reg;
   logic [CFG_BITS-1:0] window_reg;
   logic [SEQ_BITS-1:0] win_base;
   bit                  slot_full [SEQ_SPACE];
   logic [63:0]         slot_word [SEQ_SPACE];
   rsp_item_type        awaited_rsp [$];

   function automatic int clamp_modulus(logic [CFG_BITS-1:0] v);
      if (v < MODULUS_MIN) return int'(MODULUS_MIN);
      if (v > MODULUS_MAX) return int'(MODULUS_MAX);
      return int'(v);
   endfunction

   function automatic int clamp_window(logic [CFG_BITS-1:0] v, int m);
      if (v < WINDOW_MIN) return int'(WINDOW_MIN);
      if (int'(v) > m) return m;
      return int'(v);
   endfunction

   assign active_modulus = clamp_modulus(modulus_reg);
   assign active_window  = clamp_window(window_reg, active_modulus);
   assign predicted_base = win_base;

   task automatic restart_window();
      win_base = '0;
      for (int i = 0; i < SEQ_SPACE; i++) slot_full[i] = 1'b0;
   endtask

   // buffer one packet and queue the ack plus the in-order run it releases
   task automatic receive_packet(input logic ok, input logic [SEQ_BITS-1:0] seq,
                                 input logic [63:0] word);
      int m;
      int w;
      int b;
      int run;
      int p;
      rsp_item_type r;
      m = clamp_modulus(modulus_reg);
      w = clamp_window(window_reg, m);
      b = int'(win_base) % m;
      if (!ok) return;
      r.is_delivery = 1'b0;
      r.ack_num     = seq;
      r.data_out    = '0;
      // numbers at or above the modulus never fall in the window
      if (int'(seq) >= m || ((int'(seq) + m - b) % m) >= w) begin
         r.last = 1'b1;
         awaited_rsp.push_back(r);
         return;
      end
      slot_word[seq] = word & PAYLOAD_MASK;
      slot_full[seq] = 1'b1;
      run = 0;
      p = b;
      while (run < m && slot_full[p]) begin
         run++;
         p = (p + 1) % m;
      end
      r.last = (run == 0);
      awaited_rsp.push_back(r);
      for (int k = 0; k < run; k++) begin
         r.is_delivery = 1'b1;
         r.ack_num     = '0;
         r.data_out    = slot_word[b];
         r.last        = (k == run - 1);
         awaited_rsp.push_back(r);
         slot_full[b] = 1'b0;
         b = (b + 1) % m;
      end
      win_base = SEQ_BITS'(b);
   endtask

   initial begin
      modulus_reg = MODULUS_RESET;
      window_reg  = WINDOW_RESET;
      win_base    = '0;
      error_count = 0;
      awaited_count = 0;
      for (int i = 0; i < SEQ_SPACE; i++) begin
         slot_full[i] = 1'b0;
         slot_word[i] = '0;
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         modulus_reg = MODULUS_RESET;
         window_reg  = WINDOW_RESET;
         restart_window();
         awaited_rsp.delete();
      end else begin
         // results of an earlier item come before any item taken at this edge
         if (rsp_valid === 1'b1) begin
            if (awaited_rsp.size() == 0) begin
               $error("unexpected result: is_delivery %0d ack_num %0d data_out %h last %0d",
                      rsp_is_delivery, rsp_ack_num, rsp_data_out, rsp_last);
               error_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_is_delivery !== want.is_delivery) begin
                  $error("is_delivery: expected %0d, got %0d", want.is_delivery,
                         rsp_is_delivery);
                  error_count++;
               end
               if (rsp_ack_num !== want.ack_num) begin
                  $error("ack_num: expected %0d, got %0d", want.ack_num, rsp_ack_num);
                  error_count++;
               end
               if (rsp_data_out !== want.data_out) begin
                  $error("data_out: expected %h, got %h", want.data_out, rsp_data_out);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SEQ_MODULUS: begin
                  modulus_reg = csr_data;
                  restart_window();
               end
               CSR_WINDOW_SIZE: begin
                  window_reg = csr_data;
                  restart_window();
               end
               default: ;
            endcase
         end
         if (start && !busy) receive_packet(req_checksum_ok, req_seq_num, req_payload);
      end
      awaited_count <= awaited_rsp.size();
   end

endmodule

// ===== sim/selective_repeat_receiver_unit_tb.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit_tb
// Drives packets and register writes into the receiver: a directed opening
// on the reset window, then window rounds in random order with retransmits,
// dropped copies and stray packets over a range of modulus and window
// settings. The checker beside the block does all result checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module selective_repeat_receiver_unit_tb;
   import srr_pkg::*;

   localparam int LIMIT = 200000;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic                    req_checksum_ok;
   logic [SEQ_BITS-1:0]     req_seq_num;
   logic [63:0]             req_payload;
   logic                    rsp_valid;
   logic                    rsp_is_delivery;
   logic [SEQ_BITS-1:0]     rsp_ack_num;
   logic [63:0]             rsp_data_out;
   logic                    rsp_last;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]     csr_data;

   logic [SEQ_BITS-1:0]     predicted_base;
   int                      active_modulus;
   int                      active_window;
   int                      awaited_count;
   int                      error_count;

   int                      cycle_count;
   bit                      gaps_on;

   selective_repeat_receiver_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_checksum_ok (req_checksum_ok),
      .req_seq_num     (req_seq_num),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_is_delivery (rsp_is_delivery),
      .rsp_ack_num     (rsp_ack_num),
      .rsp_data_out    (rsp_data_out),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   selective_repeat_receiver_unit_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_checksum_ok (req_checksum_ok),
      .req_seq_num     (req_seq_num),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_is_delivery (rsp_is_delivery),
      .rsp_ack_num     (rsp_ack_num),
      .rsp_data_out    (rsp_data_out),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .predicted_base  (predicted_base),
      .active_modulus  (active_modulus),
      .active_window   (active_window),
      .awaited_count   (awaited_count),
      .error_count     (error_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_packet(input logic ok, input logic [SEQ_BITS-1:0] seq,
                              input logic [63:0] word);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           = 1'b1;
      req_checksum_ok = ok;
      req_seq_num     = seq;
      req_payload     = word;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // only while idle: all owed results in, then room for a dropped packet
   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] value);
      start = 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // rounds cover the whole window from the current base, out of order
   task automatic run_phase(input logic [CFG_BITS-1:0] mod_val,
                            input logic [CFG_BITS-1:0] win_val, input int n_items);
      int sent;
      int m;
      int w;
      int b;
      int j;
      int t;
      int ord [SEQ_SPACE];
      write_csr(CSR_SEQ_MODULUS, mod_val);
      write_csr(CSR_WINDOW_SIZE, win_val);
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 4) == 0) begin
            // stray packet: any number, checksum either way
            t = $urandom_range(0, 1);
            send_packet(t[0], SEQ_BITS'($urandom_range(0, SEQ_SPACE - 1)),
                        {$urandom, $urandom});
            if (t[0]) sent++;
         end else begin
            m = active_modulus;
            w = active_window;
            b = int'(predicted_base);
            for (int k = 0; k < w; k++) ord[k] = (b + k) % m;
            if ($urandom_range(0, 3) == 0) begin
               // base slot last, so the whole window is released at once
               for (int k = 0; k < w; k++) ord[k] = (b + w - 1 - k) % m;
            end else begin
               for (int k = w - 1; k > 0; k--) begin
                  j = $urandom_range(0, k);
                  t = ord[k];
                  ord[k] = ord[j];
                  ord[j] = t;
               end
            end
            for (int k = 0; k < w; k++) begin
               if ($urandom_range(0, 5) == 0)
                  send_packet(1'b0, SEQ_BITS'(ord[k]), {$urandom, $urandom});
               send_packet(1'b1, SEQ_BITS'(ord[k]), {$urandom, $urandom});
               sent++;
               if ($urandom_range(0, 7) == 0) begin
                  send_packet(1'b1, SEQ_BITS'(ord[$urandom_range(0, k)]),
                              {$urandom, $urandom});
                  sent++;
               end
            end
         end
      end
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_checksum_ok = 1'b0;
      req_seq_num     = '0;
      req_payload     = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_SEQ_MODULUS;
      csr_data        = '0;
      cycle_count     = 0;
      gaps_on         = 1'b1;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset window: modulus 8, width 4, base 0
      send_packet(1'b0, 4'd0, {64{1'b1}});
      send_packet(1'b1, 4'd1, 64'h0);
      send_packet(1'b1, 4'd4, 64'h1234_5678_9abc_def0);
      send_packet(1'b1, 4'd8, 64'h0f0f_0f0f_0f0f_0f0f);
      send_packet(1'b1, 4'd15, {64{1'b1}});
      send_packet(1'b1, 4'd3, {64{1'b1}});
      send_packet(1'b1, 4'd0, 64'h1);
      send_packet(1'b1, 4'd2, 64'h8000_0000_0000_0000);
      // old number behind the base is only acked
      send_packet(1'b1, 4'd1, 64'hdead_beef_0000_0001);
      send_packet(1'b1, 4'd7, 64'h5555_5555_5555_5555);
      send_packet(1'b1, 4'd7, 64'ha5a5_a5a5_a5a5_a5a5);
      send_packet(1'b1, 4'd6, 64'haaaa_aaaa_aaaa_aaaa);
      send_packet(1'b1, 4'd5, 64'h7fff_ffff_ffff_ffff);
      send_packet(1'b0, 4'd4, 64'h0);
      // releases 4..7 and wraps the base to 0
      send_packet(1'b1, 4'd4, 64'hfedc_ba98_7654_3210);
      send_packet(1'b1, 4'd9, 64'h0);
      send_packet(1'b0, 4'd15, {64{1'b1}});
      send_packet(1'b1, 4'd0, 64'h0);

      run_phase(5'd2, 5'd1, 25);
      run_phase(5'd16, 5'd16, 30);
      run_phase(5'd16, 5'd1, 20);
      run_phase(5'd2, 5'd2, 20);
      write_csr(CSR_UNUSED, 5'd31);
      run_phase(5'd5, 5'd3, 25);
      run_phase(5'd0, 5'd0, 20);
      run_phase(5'd31, 5'd31, 30);
      run_phase(5'd1, 5'd31, 20);
      run_phase(5'd17, 5'd4, 25);
      run_phase(5'd7, 5'd7, 25);
      run_phase(5'd12, 5'd20, 25);
      gaps_on = 1'b0;
      run_phase(5'd8, 5'd4, 35);

      start = 1'b0;
      while (awaited_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/srr_pkg.sv
rtl/core/srr_ctrl.sv
rtl/core/srr_dpath.sv
rtl/core/selective_repeat_receiver_unit.sv
sim/selective_repeat_receiver_unit_checker.sv
sim/selective_repeat_receiver_unit_tb.sv
